/* rtl/core/tscs_pkg.sv */
`default_nettype none

package tscs_pkg;

  // Fixed-point widths, all set by the Q3.28 angle range (|x| <= 8 rad).
  localparam int unsigned ANGLE_W  = 32;  // input angle, Q3.28
  localparam int unsigned OUT_W    = 32;  // result value, Q11.20
  localparam int unsigned X2_W     = 35;  // x squared, Q6.28
  localparam int unsigned MAG_W    = 42;  // series term magnitude, Q.32
  localparam int unsigned HALF_W   = MAG_W / 2;
  localparam int unsigned N_W      = 48;  // rounded dividend of one term step
  localparam int unsigned SUM_W    = 46;  // signed series sum, Q.32
  localparam int unsigned REM_W    = 45;  // sum magnitude / divider remainder
  localparam int unsigned Q_W      = 31;  // tangent quotient bits
  localparam int unsigned FRAC_IN  = 28;
  localparam int unsigned FRAC_INT = 32;
  localparam int unsigned FRAC_OUT = 20;
  localparam int unsigned INT_Q    = Q_W - FRAC_OUT;

  // Function select codes
  localparam logic [1:0] OP_SIN = 2'd0;
  localparam logic [1:0] OP_COS = 2'd1;
  localparam logic [1:0] OP_TAN = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] op;
  } ctl_t;

  // Result as it travels beside the tangent divider
  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             zero_cos;
    logic             sat;
    logic             use_div;  // take the value from the divider
    logic             neg;      // sign of the quotient
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/tscs_term_cell.sv */
`default_nettype none

// One series step: mag * x2 >> 28 (rounded), then / D (rounded) by reciprocal.
// Adds the incoming term to the running sum. Five register stages.
module tscs_term_cell #(
  parameter int unsigned D = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  tscs_pkg::ctl_t                        ctl_i,
  input  logic [tscs_pkg::X2_W-1:0]             x2_i,
  input  logic [tscs_pkg::MAG_W-1:0]            mag_i,
  input  logic                                  neg_i,
  input  logic signed [tscs_pkg::SUM_W-1:0]     sum_i,
  output tscs_pkg::ctl_t                        ctl_o,
  output logic [tscs_pkg::X2_W-1:0]             x2_o,
  output logic [tscs_pkg::MAG_W-1:0]            mag_o,
  output logic                                  neg_o,
  output logic signed [tscs_pkg::SUM_W-1:0]     sum_o
);

  localparam int unsigned X2_W   = tscs_pkg::X2_W;
  localparam int unsigned MAG_W  = tscs_pkg::MAG_W;
  localparam int unsigned HALF_W = tscs_pkg::HALF_W;
  localparam int unsigned N_W    = tscs_pkg::N_W;
  localparam int unsigned NH     = N_W / 2;
  localparam int unsigned SUM_W  = tscs_pkg::SUM_W;
  localparam int unsigned PP_W   = HALF_W + X2_W;
  localparam int unsigned PROD_W = MAG_W + X2_W;
  localparam int unsigned FULL_W = 2 * N_W;
  localparam logic [63:0] ONE_K  = 64'd1 << N_W;
  localparam logic [N_W-1:0] RECIP  = N_W'(ONE_K / 64'(D));
  localparam logic [N_W-1:0] D_N    = N_W'(D);
  localparam logic [N_W-1:0] HALF_D = N_W'(D / 2);

  tscs_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;
  logic [X2_W-1:0] x2_1_q, x2_2_q, x2_3_q, x2_4_q, x2_5_q;
  logic neg1_q, neg2_q, neg3_q, neg4_q, neg5_q;
  logic signed [SUM_W-1:0] sum1_q, sum2_q, sum3_q, sum4_q, sum5_q;
  logic signed [SUM_W-1:0] term_s, sum1_d;
  logic [PP_W-1:0] pplo_q, pphi_q;
  logic [PROD_W-1:0] prod, prod_rnd;
  logic [N_W-1:0] n2_d, n2_q, n3_q, n4_q;
  logic [N_W-1:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic [FULL_W-1:0] full;
  logic [MAG_W-1:0] qe4_q, mag5_d, mag5_q;
  logic [N_W-1:0] qd, rem;

  // stage 1: accumulate incoming term, split product
  always_comb begin
    term_s = $signed({{(SUM_W-MAG_W){1'b0}}, mag_i});
    if (neg_i) begin
      term_s = -term_s;
    end
    sum1_d = sum_i + term_s;
  end

  // stage 2: join partial products, round off 28 bits, add D/2
  always_comb begin
    prod     = (PROD_W'(pphi_q) << HALF_W) + PROD_W'(pplo_q);
    prod_rnd = prod + (PROD_W'(1) << (tscs_pkg::FRAC_IN - 1));
    n2_d     = N_W'(prod_rnd >> tscs_pkg::FRAC_IN) + HALF_D;
  end

  // stage 4: estimate quotient, low by at most one
  always_comb begin
    full = (FULL_W'(pp11_q) << N_W)
         + ((FULL_W'(pp01_q) + FULL_W'(pp10_q)) << NH)
         + FULL_W'(pp00_q);
  end

  // stage 5: correct quotient
  always_comb begin
    qd     = N_W'(N_W'(qe4_q) * D_N);
    rem    = n4_q - qd;
    mag5_d = (rem >= D_N) ? qe4_q + MAG_W'(1) : qe4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_1_q <= x2_i;
      neg1_q <= !neg_i;
      sum1_q <= sum1_d;
      pplo_q <= PP_W'(mag_i[HALF_W-1:0]) * PP_W'(x2_i);
      pphi_q <= PP_W'(mag_i[MAG_W-1:HALF_W]) * PP_W'(x2_i);

      x2_2_q <= x2_1_q;
      neg2_q <= neg1_q;
      sum2_q <= sum1_q;
      n2_q   <= n2_d;

      x2_3_q <= x2_2_q;
      neg3_q <= neg2_q;
      sum3_q <= sum2_q;
      n3_q   <= n2_q;
      pp00_q <= N_W'(n2_q[NH-1:0]) * N_W'(RECIP[NH-1:0]);
      pp01_q <= N_W'(n2_q[NH-1:0]) * N_W'(RECIP[N_W-1:NH]);
      pp10_q <= N_W'(n2_q[N_W-1:NH]) * N_W'(RECIP[NH-1:0]);
      pp11_q <= N_W'(n2_q[N_W-1:NH]) * N_W'(RECIP[N_W-1:NH]);

      x2_4_q <= x2_3_q;
      neg4_q <= neg3_q;
      sum4_q <= sum3_q;
      n4_q   <= n3_q;
      qe4_q  <= full[N_W +: MAG_W];

      x2_5_q <= x2_4_q;
      neg5_q <= neg4_q;
      sum5_q <= sum4_q;
      mag5_q <= mag5_d;
    end
  end

  assign ctl_o = ctl5_q;
  assign x2_o  = x2_5_q;
  assign mag_o = mag5_q;
  assign neg_o = neg5_q;
  assign sum_o = sum5_q;

endmodule

`default_nettype wire

/* rtl/core/tscs_div_cell.sv */
`default_nettype none

// One restoring-division step: one quotient bit per cell.
// shq holds pending dividend bits at the top, quotient bits fill from the bottom.
module tscs_div_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  tscs_pkg::ctl_t                ctl_i,
  input  tscs_pkg::res_t                res_i,
  input  logic [tscs_pkg::REM_W-1:0]    rem_i,
  input  logic [tscs_pkg::Q_W-1:0]      shq_i,
  input  logic [tscs_pkg::REM_W-1:0]    dvs_i,
  output tscs_pkg::ctl_t                ctl_o,
  output tscs_pkg::res_t                res_o,
  output logic [tscs_pkg::REM_W-1:0]    rem_o,
  output logic [tscs_pkg::Q_W-1:0]      shq_o,
  output logic [tscs_pkg::REM_W-1:0]    dvs_o
);

  localparam int unsigned REM_W = tscs_pkg::REM_W;
  localparam int unsigned Q_W   = tscs_pkg::Q_W;

  logic [REM_W:0]   trial, diff;
  logic             ge;
  logic [REM_W-1:0] rem_d;
  tscs_pkg::ctl_t   ctl_q;

  always_comb begin
    trial = {rem_i, shq_i[Q_W-1]};
    diff  = trial - {1'b0, dvs_i};
    ge    = trial >= {1'b0, dvs_i};
    rem_d = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_i;
      rem_o <= rem_d;
      shq_o <= {shq_i[Q_W-2:0], ge};
      dvs_o <= dvs_i;
    end
  end

  assign ctl_o = ctl_q;

endmodule

`default_nettype wire

/* rtl/core/taylor_sine_cosine_tangent_core.sv */
// Throughput: one request per cycle while the output buffer is not full; every request yields one result.
// Sine and cosine chains (5 stages per term) and a 31-cell tangent divider all run
// every request; a 2-entry output buffer decouples the stall from the result side.
// Reset: rst_ni asynchronous, active low; clears valid bits and the buffer count.
`default_nettype none

module taylor_sine_cosine_tangent_core #(
  parameter int unsigned TERMS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] angle
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] value
  output logic [1:0]  m_axis_tuser_o    // [0] zero_cosine, [1] saturated
);

  localparam int unsigned ANGLE_W  = tscs_pkg::ANGLE_W;
  localparam int unsigned OUT_W    = tscs_pkg::OUT_W;
  localparam int unsigned X2_W     = tscs_pkg::X2_W;
  localparam int unsigned MAG_W    = tscs_pkg::MAG_W;
  localparam int unsigned SUM_W    = tscs_pkg::SUM_W;
  localparam int unsigned REM_W    = tscs_pkg::REM_W;
  localparam int unsigned Q_W      = tscs_pkg::Q_W;
  localparam int unsigned FRAC_IN  = tscs_pkg::FRAC_IN;
  localparam int unsigned INT_Q    = tscs_pkg::INT_Q;
  localparam int unsigned FRAC_OUT = tscs_pkg::FRAC_OUT;
  localparam int unsigned SHIFT_O  = tscs_pkg::FRAC_INT - FRAC_OUT;
  localparam int unsigned SQ_W     = 2 * ANGLE_W;
  localparam int unsigned R_W      = OUT_W + 2;
  localparam int unsigned BIG_W    = REM_W + INT_Q;
  localparam int unsigned ENT_W    = OUT_W + 2;
  localparam logic [R_W-1:0] POS_LIM = R_W'(34'h0_7FFF_FFFF);
  localparam logic [R_W-1:0] NEG_LIM = R_W'(34'h0_8000_0000);

  // Clip a sign and Q11.20 magnitude; returns {saturated, value}.
  function automatic logic [OUT_W:0] clip_out(input logic neg, input logic [R_W-1:0] r);
    logic [R_W-1:0] lim;
    logic           sat;
    logic [R_W-1:0] neg_r;
    lim   = r;
    sat   = 1'b0;
    neg_r = '0;
    if (neg) begin
      if (r > NEG_LIM) begin
        sat = 1'b1;
        lim = NEG_LIM;
      end
      neg_r = R_W'(0) - lim;
      return {sat, neg_r[OUT_W-1:0]};
    end
    if (r > POS_LIM) begin
      sat = 1'b1;
      lim = POS_LIM;
    end
    return {sat, lim[OUT_W-1:0]};
  endfunction

  // Global advance: the whole pipe moves unless the output buffer is full.
  logic [1:0] cnt_q, cnt_d;
  logic       en;
  assign en              = (cnt_q != 2'd2);
  assign s_axis_tready_o = en;

  // ---------------- front end: |x| and x^2 ----------------
  tscs_pkg::ctl_t       a_ctl_q, b_ctl_q, c_ctl_q;
  logic                 a_xneg_q, b_xneg_q, c_sneg_q;
  logic [ANGLE_W-1:0]   a_xmag_q, b_xmag_q, a_xmag_d;
  logic [SQ_W-1:0]      b_sq_q, sq_rnd;
  logic [X2_W-1:0]      c_x2_q;
  logic [MAG_W-1:0]     c_smag_q;

  always_comb begin
    a_xmag_d = s_axis_tdata_i[ANGLE_W-1] ? ANGLE_W'(0) - s_axis_tdata_i : s_axis_tdata_i;
    sq_rnd   = b_sq_q + (SQ_W'(1) << (FRAC_IN - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
      b_ctl_q <= '0;
      c_ctl_q <= '0;
    end else if (en) begin
      a_ctl_q <= '{valid: s_axis_tvalid_i, op: s_axis_tuser_i};
      b_ctl_q <= a_ctl_q;
      c_ctl_q <= b_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_xneg_q <= s_axis_tdata_i[ANGLE_W-1];
      a_xmag_q <= a_xmag_d;
      b_xneg_q <= a_xneg_q;
      b_xmag_q <= a_xmag_q;
      b_sq_q   <= SQ_W'(a_xmag_q) * SQ_W'(a_xmag_q);
      c_sneg_q <= b_xneg_q;
      c_x2_q   <= X2_W'(sq_rnd >> FRAC_IN);
      c_smag_q <= MAG_W'(b_xmag_q) << (tscs_pkg::FRAC_INT - FRAC_IN);
    end
  end

  // ---------------- series chains: sine and cosine ----------------
  tscs_pkg::ctl_t          sn_ctl [TERMS+1];
  logic [X2_W-1:0]         sn_x2  [TERMS+1];
  logic [MAG_W-1:0]        sn_mag [TERMS+1];
  logic                    sn_neg [TERMS+1];
  logic signed [SUM_W-1:0] sn_sum [TERMS+1];
  tscs_pkg::ctl_t          cs_ctl [TERMS+1];
  logic [X2_W-1:0]         cs_x2  [TERMS+1];
  logic [MAG_W-1:0]        cs_mag [TERMS+1];
  logic                    cs_neg [TERMS+1];
  logic signed [SUM_W-1:0] cs_sum [TERMS+1];

  // first terms: sine starts at x, cosine at 1.0
  assign sn_ctl[0] = c_ctl_q;
  assign sn_x2[0]  = c_x2_q;
  assign sn_mag[0] = c_smag_q;
  assign sn_neg[0] = c_sneg_q;
  assign sn_sum[0] = '0;
  assign cs_ctl[0] = c_ctl_q;
  assign cs_x2[0]  = c_x2_q;
  assign cs_mag[0] = MAG_W'(1) << tscs_pkg::FRAC_INT;
  assign cs_neg[0] = 1'b0;
  assign cs_sum[0] = '0;

  for (genvar g = 0; g < TERMS; g++) begin : g_term
    tscs_term_cell #(
      .D ((2 * (g + 1)) * (2 * (g + 1) + 1))
    ) u_sin (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (sn_ctl[g]),
      .x2_i   (sn_x2[g]),
      .mag_i  (sn_mag[g]),
      .neg_i  (sn_neg[g]),
      .sum_i  (sn_sum[g]),
      .ctl_o  (sn_ctl[g+1]),
      .x2_o   (sn_x2[g+1]),
      .mag_o  (sn_mag[g+1]),
      .neg_o  (sn_neg[g+1]),
      .sum_o  (sn_sum[g+1])
    );
    tscs_term_cell #(
      .D ((2 * (g + 1)) * (2 * (g + 1) - 1))
    ) u_cos (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (cs_ctl[g]),
      .x2_i   (cs_x2[g]),
      .mag_i  (cs_mag[g]),
      .neg_i  (cs_neg[g]),
      .sum_i  (cs_sum[g]),
      .ctl_o  (cs_ctl[g+1]),
      .x2_o   (cs_x2[g+1]),
      .mag_o  (cs_mag[g+1]),
      .neg_o  (cs_neg[g+1]),
      .sum_o  (cs_sum[g+1])
    );
  end

  // ---------------- tail: last term, magnitudes, result prep ----------------
  tscs_pkg::ctl_t          t_ctl_q, p1_ctl_q, p2_ctl_q;
  logic signed [SUM_W-1:0] t_s_q, t_c_q, sn_term, cs_term;
  logic                    p1_sneg_q, p1_cneg_q, p1_czero_q;
  logic [REM_W-1:0]        p1_smag_q, p1_cmag_q, s_abs, c_abs;
  logic [R_W-1:0]          sc_r;
  logic [OUT_W:0]          sc_clip, big_clip;
  logic                    big, q_neg;
  tscs_pkg::res_t          p2_res_d, p2_res_q;
  logic [REM_W-1:0]        p2_rem_q, p2_dvs_q;
  logic [Q_W-1:0]          p2_shq_q;

  always_comb begin
    sn_term = $signed({{(SUM_W-MAG_W){1'b0}}, sn_mag[TERMS]});
    cs_term = $signed({{(SUM_W-MAG_W){1'b0}}, cs_mag[TERMS]});
    if (sn_neg[TERMS]) begin
      sn_term = -sn_term;
    end
    if (cs_neg[TERMS]) begin
      cs_term = -cs_term;
    end
    s_abs = t_s_q[SUM_W-1] ? REM_W'(-t_s_q) : REM_W'(t_s_q);
    c_abs = t_c_q[SUM_W-1] ? REM_W'(-t_c_q) : REM_W'(t_c_q);
  end

  // Sine/cosine rounding (half away from zero on the magnitude) and tangent setup
  always_comb begin
    sc_r     = (p1_ctl_q.op == tscs_pkg::OP_SIN)
             ? R_W'((p1_smag_q + (REM_W'(1) << (SHIFT_O - 1))) >> SHIFT_O)
             : R_W'((p1_cmag_q + (REM_W'(1) << (SHIFT_O - 1))) >> SHIFT_O);
    sc_clip  = clip_out((p1_ctl_q.op == tscs_pkg::OP_SIN) ? p1_sneg_q : p1_cneg_q, sc_r);
    q_neg    = p1_sneg_q ^ p1_cneg_q;
    big      = BIG_W'(p1_smag_q) >= (BIG_W'(p1_cmag_q) << INT_Q);
    big_clip = clip_out(q_neg, R_W'(1) << OUT_W);
    p2_res_d = '0;
    case (p1_ctl_q.op) inside
      tscs_pkg::OP_SIN, tscs_pkg::OP_COS: begin
        p2_res_d.value = sc_clip[OUT_W-1:0];
        p2_res_d.sat   = sc_clip[OUT_W];
      end
      tscs_pkg::OP_TAN: begin
        if (p1_czero_q) begin
          p2_res_d.zero_cos = 1'b1;
        end else if (big) begin
          p2_res_d.value = big_clip[OUT_W-1:0];
          p2_res_d.sat   = big_clip[OUT_W];
        end else begin
          p2_res_d.use_div = 1'b1;
          p2_res_d.neg     = q_neg;
        end
      end
      default: begin
        p2_res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_ctl_q  <= '0;
      p1_ctl_q <= '0;
      p2_ctl_q <= '0;
    end else if (en) begin
      t_ctl_q  <= sn_ctl[TERMS];
      p1_ctl_q <= t_ctl_q;
      p2_ctl_q <= p1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_s_q      <= sn_sum[TERMS] + sn_term;
      t_c_q      <= cs_sum[TERMS] + cs_term;
      p1_sneg_q  <= t_s_q[SUM_W-1];
      p1_cneg_q  <= t_c_q[SUM_W-1];
      p1_czero_q <= (t_c_q == '0);
      p1_smag_q  <= s_abs;
      p1_cmag_q  <= c_abs;
      p2_res_q   <= p2_res_d;
      // all but the low INT_Q bits of |sin| go straight into the remainder
      p2_rem_q   <= p1_smag_q >> INT_Q;
      p2_shq_q   <= {p1_smag_q[INT_Q-1:0], {FRAC_OUT{1'b0}}};
      p2_dvs_q   <= p1_cmag_q;
    end
  end

  // ---------------- tangent divider chain ----------------
  tscs_pkg::ctl_t   dv_ctl [Q_W+1];
  tscs_pkg::res_t   dv_res [Q_W+1];
  logic [REM_W-1:0] dv_rem [Q_W+1];
  logic [Q_W-1:0]   dv_shq [Q_W+1];
  logic [REM_W-1:0] dv_dvs [Q_W+1];

  assign dv_ctl[0] = p2_ctl_q;
  assign dv_res[0] = p2_res_q;
  assign dv_rem[0] = p2_rem_q;
  assign dv_shq[0] = p2_shq_q;
  assign dv_dvs[0] = p2_dvs_q;

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    tscs_div_cell u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (dv_ctl[k]),
      .res_i  (dv_res[k]),
      .rem_i  (dv_rem[k]),
      .shq_i  (dv_shq[k]),
      .dvs_i  (dv_dvs[k]),
      .ctl_o  (dv_ctl[k+1]),
      .res_o  (dv_res[k+1]),
      .rem_o  (dv_rem[k+1]),
      .shq_o  (dv_shq[k+1]),
      .dvs_o  (dv_dvs[k+1])
    );
  end

  // ---------------- finish: quotient rounding, result select ----------------
  tscs_pkg::res_t   fin_res;
  logic             q_up, push, pop, fin_valid;
  logic [R_W-1:0]   q_r;
  logic [OUT_W:0]   q_clip;
  logic [ENT_W-1:0] fin_ent, b0_q, b1_q;

  always_comb begin
    fin_res   = dv_res[Q_W];
    fin_valid = dv_ctl[Q_W].valid;
    q_up      = {dv_rem[Q_W], 1'b0} >= {1'b0, dv_dvs[Q_W]};
    q_r       = R_W'(dv_shq[Q_W]) + R_W'(q_up);
    q_clip    = clip_out(fin_res.neg, q_r);
    if (fin_res.use_div) begin
      fin_ent = {q_clip[OUT_W], 1'b0, q_clip[OUT_W-1:0]};
    end else begin
      fin_ent = {fin_res.sat, fin_res.zero_cos, fin_res.value};
    end
  end

  // ---------------- 2-entry output buffer ----------------
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign pop             = m_axis_tvalid_o & m_axis_tready_i;
  assign push            = en & fin_valid;
  assign cnt_d           = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && (cnt_q == 2'd0 || pop)) begin
      b0_q <= fin_ent;
    end else if (pop) begin
      b0_q <= b1_q;
    end
    if (push && cnt_q == 2'd1 && !pop) begin
      b1_q <= fin_ent;
    end
  end

  assign m_axis_tdata_o = b0_q[OUT_W-1:0];
  assign m_axis_tuser_o = b0_q[ENT_W-1:OUT_W];

  // ---------------- checks ----------------
  // both series chains carry the same request stream
  a_chain_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sn_ctl[TERMS].valid == cs_ctl[TERMS].valid)
    else $error("sine and cosine chains out of step");

  // nothing accepted while the output buffer is full
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !s_axis_tready_o)
    else $error("request accepted with full output buffer");

  // zero cosine result is a clean zero
  a_zero_cos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0 && !m_axis_tuser_o[1]))
    else $error("zero cosine result not clean");

  // a full buffer with no pop stays full
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !m_axis_tready_i) |=> (cnt_q == 2'd2))
    else $error("buffer count changed without a pop");

endmodule

`default_nettype wire
